// ----- rtl/core/lurt_pkg.sv -----
package lurt_pkg;

  localparam int POS_WIDTH     = 16;
  localparam int ALPHABET_SIZE = 256;
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 16;
  localparam int SYM_W         = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int EXT_W         = POS_WIDTH + LEN_W;

  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [LEN_W-1:0]     len_t;

  localparam logic [CHAR_W:0] SYM_LIMIT = (CHAR_W+1)'(ALPHABET_SIZE);
  localparam sym_t            SYM_MAX   = SYM_W'(ALPHABET_SIZE - 1);
  localparam pos_t            POS_MAX   = '1;
  localparam len_t            LEN_MAX   = '1;

  // One classified character on its way from front to back.
  typedef struct packed {
    sym_t sym;
    logic first;
    logic last;
  } item_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    len_t longest_length;
    logic length_overflow;
  } res_t;

  // Clip a run length to the result width; the top bit flags a clip.
  function automatic logic [LEN_W:0] sat_len(input pos_t v);
    logic [EXT_W-1:0] wide;
    wide = EXT_W'(v);
    if (wide > EXT_W'(LEN_MAX)) begin
      return {1'b1, LEN_MAX};
    end
    return {1'b0, wide[LEN_W-1:0]};
  endfunction

endpackage

// ----- rtl/core/lurt_char_if.sv -----
interface lurt_char_if;
  logic                        valid;
  logic                        ready;
  logic [lurt_pkg::CHAR_W-1:0] char_byte;
  logic                        first_char;
  logic                        last_char;

  modport source (output valid, output char_byte, output first_char, output last_char,
                  input ready);
  modport sink   (input valid, input char_byte, input first_char, input last_char,
                  output ready);
endinterface

// ----- rtl/core/lurt_res_if.sv -----
interface lurt_res_if;
  logic                valid;
  logic                ready;
  lurt_pkg::len_t      longest_length;
  logic                length_overflow;

  modport source (output valid, output longest_length, output length_overflow,
                  input ready);
  modport sink   (input valid, input longest_length, input length_overflow,
                  output ready);
endinterface

// ----- rtl/core/lurt_ram.sv -----
module lurt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lurt_front.sv -----
module lurt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lurt_char_if.sink           char_i,
  input  logic                pop_i,
  output lurt_pkg::q_head_t   head_o
);

  lurt_pkg::item_t item_in;
  lurt_pkg::item_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            pop;

  // Clamp characters beyond the alphabet to its top symbol.
  always_comb begin
    if ({1'b0, char_i.char_byte} >= lurt_pkg::SYM_LIMIT) begin
      item_in.sym = lurt_pkg::SYM_MAX;
    end else begin
      item_in.sym = lurt_pkg::SYM_W'(char_i.char_byte);
    end
    item_in.first = char_i.first_char;
    item_in.last  = char_i.last_char;
  end

  assign char_i.ready = (count_q != 2'd2);
  assign push         = char_i.valid && char_i.ready;
  assign pop          = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- rtl/core/lurt_back.sv -----
module lurt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lurt_pkg::q_head_t   head_i,
  output logic                pop_o,
  lurt_res_if.source          res_o
);

  logic                             b_valid_q, b_valid_d;
  lurt_pkg::item_t                  b_item_q;
  lurt_pkg::pos_t                   pos_q, pos_d;
  lurt_pkg::pos_t                   ws_q, ws_d;
  lurt_pkg::pos_t                   best_q, best_d;
  logic                             ovf_q, ovf_d;
  logic [lurt_pkg::ALPHABET_SIZE-1:0] seen_q, seen_d;
  logic                             fwd_valid_q;
  lurt_pkg::sym_t                   fwd_sym_q;
  lurt_pkg::pos_t                   fwd_pos_q;
  logic                             out_valid_q, out_valid_d;
  lurt_pkg::res_t                   out_res_q;

  logic                             b_go;
  lurt_pkg::sym_t                   raddr;
  lurt_pkg::pos_t                   ram_rdata;
  lurt_pkg::pos_t                   lsp;
  lurt_pkg::pos_t                   idx, ws0, ws_new, best_base, len_sat;
  logic [lurt_pkg::POS_WIDTH:0]     lsp_inc, len;
  logic                             hit, len_ovf, pos_full, ovf_new;
  logic [lurt_pkg::LEN_W:0]         clip;

  // Stall only a last character while the result register is still occupied.
  assign b_go  = b_valid_q && (!b_item_q.last || !out_valid_q || res_o.ready);
  assign pop_o = head_i.valid && (!b_valid_q || b_go);
  // Re-read the held symbol during a stall so the read data stays current.
  assign raddr = pop_o ? head_i.item.sym : b_item_q.sym;

  lurt_ram #(
    .WIDTH(lurt_pkg::POS_WIDTH),
    .DEPTH(lurt_pkg::ALPHABET_SIZE)
  ) u_last_seen (
    .clk_i  (clk_i),
    .we_i   (b_go),
    .waddr_i(b_item_q.sym),
    .wdata_i(idx),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    idx       = b_item_q.first ? '0 : pos_q;
    ws0       = b_item_q.first ? '0 : ws_q;
    best_base = b_item_q.first ? '0 : best_q;
    // Forward the latest write, which the read in flight may have missed.
    lsp       = (fwd_valid_q && (fwd_sym_q == b_item_q.sym)) ? fwd_pos_q : ram_rdata;
    hit       = !b_item_q.first && seen_q[b_item_q.sym] && (lsp >= ws0);
    lsp_inc   = {1'b0, lsp} + 1'b1;
    if (!hit) begin
      ws_new = ws0;
    end else if (lsp_inc > {1'b0, idx}) begin
      ws_new = idx;
    end else begin
      ws_new = lsp_inc[lurt_pkg::POS_WIDTH-1:0];
    end
    len     = {1'b0, idx} - {1'b0, ws_new} + 1'b1;
    len_ovf = (len > {1'b0, lurt_pkg::POS_MAX});
    len_sat = len_ovf ? lurt_pkg::POS_MAX : len[lurt_pkg::POS_WIDTH-1:0];
    pos_full = (idx == lurt_pkg::POS_MAX);
    ovf_new  = (!b_item_q.first && ovf_q) || len_ovf || pos_full;

    best_d = (len_sat > best_base) ? len_sat : best_base;
    ws_d   = ws_new;
    pos_d  = pos_full ? idx : idx + 1'b1;
    ovf_d  = ovf_new;
    seen_d = b_item_q.first ? '0 : seen_q;
    seen_d[b_item_q.sym] = 1'b1;
    clip   = lurt_pkg::sat_len(best_d);
  end

  assign b_valid_d   = pop_o || (b_valid_q && !b_go);
  assign out_valid_d = (b_go && b_item_q.last) || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      pos_q       <= '0;
      ws_q        <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (b_go) begin
        pos_q       <= pos_d;
        ws_q        <= ws_d;
        best_q      <= best_d;
        ovf_q       <= ovf_d;
        seen_q      <= seen_d;
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q <= head_i.item;
    end
    if (b_go) begin
      fwd_sym_q <= b_item_q.sym;
      fwd_pos_q <= idx;
    end
    if (b_go && b_item_q.last) begin
      out_res_q.longest_length  <= clip[lurt_pkg::LEN_W-1:0];
      out_res_q.length_overflow <= ovf_new || clip[lurt_pkg::LEN_W];
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.longest_length  = out_res_q.longest_length;
  assign res_o.length_overflow = out_res_q.length_overflow;

endmodule

// ----- rtl/core/longest_unique_run_tracker.sv -----
// Longest run without a repeated character, measured over a streamed string.
//
// in_char_i carries one character per request with first_char and last_char
// markers; a request is taken at a rising edge with valid and ready high.
// out_res_o carries one result per string, on its last character: the
// longest repeat-free run and a flag set when the position counter or the
// run length saturated. Characters after reset, or after a last character
// with no new first marker, continue the current string.
//
// Throughput: one character per cycle, unless a last character waits for an
// occupied result register; set by the last-seen table, a RAM with one write
// and one registered read port plus one-entry forwarding. A last character
// passes the queue entry, the table read and the result register before
// out_res_o.valid rises. A stalled receiver holds the result register; the
// back part then holds its current character only if it is a last one, and
// the two-entry queue keeps in_char_i.ready high until it fills.
// Reset clears the seen bits, counters, queue and result register at once;
// there is no clearing pass and the table contents need no reset.
module longest_unique_run_tracker (
  input  logic     clk_i,
  input  logic     rst_ni,
  lurt_char_if.sink  in_char_i,
  lurt_res_if.source out_res_o
);

  lurt_pkg::q_head_t head;
  logic              pop;

  // Front: accept requests, clamp the symbol, buffer in a short queue.
  lurt_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(in_char_i),
    .pop_i (pop),
    .head_o(head)
  );

  // Back: table lookup, window update and result register.
  lurt_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .pop_o (pop),
    .res_o (out_res_o)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  // Keep the predicted table, counters and pending results together; note
  // each accepted character request and check each result against the oldest
  // pending one.
  class unique_run_predictor;
    lurt_pkg::pos_t last_pos [lurt_pkg::ALPHABET_SIZE];
    bit             seen     [lurt_pkg::ALPHABET_SIZE];
    lurt_pkg::pos_t next_pos;
    lurt_pkg::pos_t run_start;
    lurt_pkg::pos_t best_run;
    bit             sat_flag;
    lurt_pkg::res_t expected_runs [$];
    int unsigned    mismatches;

    function new();
      foreach (seen[k]) begin
        seen[k]     = 1'b0;
        last_pos[k] = '0;
      end
      next_pos   = '0;
      run_start  = '0;
      best_run   = '0;
      sat_flag   = 1'b0;
      mismatches = 0;
    endfunction

    function void take_char(logic [lurt_pkg::CHAR_W-1:0] c, logic f, logic l);
      lurt_pkg::sym_t  s;
      longint unsigned cur;
      longint unsigned start;
      longint unsigned span;
      lurt_pkg::res_t  r;
      if ({1'b0, c} >= lurt_pkg::SYM_LIMIT) begin
        s = lurt_pkg::SYM_MAX;
      end else begin
        s = lurt_pkg::sym_t'(c);
      end
      if (f) begin
        foreach (seen[k]) seen[k] = 1'b0;
        next_pos  = '0;
        run_start = '0;
        best_run  = '0;
        sat_flag  = 1'b0;
      end
      cur   = next_pos;
      start = run_start;
      // A repeat inside the window moves its start just past the old sighting.
      if (seen[s] && last_pos[s] >= run_start) begin
        start = longint'(last_pos[s]) + 1;
        if (start > cur) start = cur;
        run_start = lurt_pkg::pos_t'(start);
      end
      span = cur - start + 1;
      if (span > lurt_pkg::POS_MAX) begin
        span     = lurt_pkg::POS_MAX;
        sat_flag = 1'b1;
      end
      if (span > best_run) best_run = lurt_pkg::pos_t'(span);
      last_pos[s] = lurt_pkg::pos_t'(cur);
      seen[s]     = 1'b1;
      if (next_pos == lurt_pkg::POS_MAX) begin
        sat_flag = 1'b1;
      end else begin
        next_pos = next_pos + 1'b1;
      end
      if (l) begin
        r.length_overflow = sat_flag;
        if (longint'(best_run) > longint'(lurt_pkg::LEN_MAX)) begin
          r.longest_length  = lurt_pkg::LEN_MAX;
          r.length_overflow = 1'b1;
        end else begin
          r.longest_length = lurt_pkg::len_t'(best_run);
        end
        expected_runs.push_back(r);
      end
    endfunction

    function void check_run(lurt_pkg::len_t got_len, logic got_ovf);
      lurt_pkg::res_t want;
      if (expected_runs.size() == 0) begin
        $display("%0t: result with nothing pending: length %0d overflow %0b",
                 $time, got_len, got_ovf);
        mismatches++;
        return;
      end
      want = expected_runs.pop_front();
      if (got_len !== want.longest_length) begin
        $display("%0t: longest_length expected %0d actual %0d",
                 $time, want.longest_length, got_len);
        mismatches++;
      end
      if (got_ovf !== want.length_overflow) begin
        $display("%0t: length_overflow expected %0b actual %0b",
                 $time, want.length_overflow, got_ovf);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lurt_char_if char_if ();
  lurt_res_if  res_if ();

  unique_run_predictor predictor = new();

  // Idling percentages for the current phase; the sender task and the receiver loop read them.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_chars     = 0;

  longest_unique_run_tracker i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_char_i (char_if),
    .out_res_o (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Hard stop: well above the slowest correct run.
  initial begin
    #10_000_000;
    $display("longest_unique_run_tracker verification failed");
    $finish;
  end

  // Receiver: decide stalls at the falling edge, take results at the rising
  // edge, before any register update of that edge is visible.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        predictor.check_run(res_if.longest_length, res_if.length_overflow);
      end
    end
  end

  // Drive one character request. Enter and leave at a falling edge; valid
  // stays high between back-to-back requests, so it is never dropped and
  // raised in the same step.
  task automatic send_char(input logic [lurt_pkg::CHAR_W-1:0] c, input logic f,
                           input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid = 1'b0;
      @(negedge clk_i);
    end
    char_if.valid      = 1'b1;
    char_if.char_byte  = c;
    char_if.first_char = f;
    char_if.last_char  = l;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    predictor.take_char(c, f, l);
    sent_chars++;
    @(negedge clk_i);
  endtask

  // Send a literal string; mark its ends only where asked.
  task automatic send_word(input string w, input bit f, input bit l);
    for (int i = 0; i < w.len(); i++) begin
      send_char(w[i], f && (i == 0), l && (i == w.len() - 1));
    end
  endtask

  // Send a string of random characters drawn from lo..hi.
  task automatic send_string(input int n, input int lo, input int hi,
                             input bit f, input bit l);
    for (int i = 0; i < n; i++) begin
      send_char(lurt_pkg::CHAR_W'($urandom_range(hi, lo)), f && (i == 0),
                l && (i == n - 1));
    end
  endtask

  // Send every character value once in shuffled order: the longest run the
  // alphabet allows.
  task automatic send_permutation();
    logic [lurt_pkg::CHAR_W-1:0] perm [lurt_pkg::ALPHABET_SIZE];
    logic [lurt_pkg::CHAR_W-1:0] tmp;
    int                          j;
    foreach (perm[k]) perm[k] = lurt_pkg::CHAR_W'(k);
    for (int k = lurt_pkg::ALPHABET_SIZE - 1; k > 0; k--) begin
      j       = $urandom_range(k);
      tmp     = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[k]) begin
      send_char(perm[k], k == 0, k == lurt_pkg::ALPHABET_SIZE - 1);
    end
  endtask

  // Random strings under one idling mix, until about target requests are in.
  task automatic run_phase(input int unsigned target, input int unsigned idle,
                           input int unsigned stall);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned span;
    int unsigned lo;
    stop_at        = sent_chars + target;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    while (sent_chars < stop_at) begin
      pick = $urandom_range(99);
      span = (1 << $urandom_range(8)) - 1;
      lo   = $urandom_range(255 - span);
      if (pick < 70) begin
        // Well-formed short string; narrow alphabets force many repeats.
        send_string($urandom_range(24, 1), lo, lo + span, 1'b1, 1'b1);
      end else if (pick < 80) begin
        send_string($urandom_range(120, 30), lo, lo + span, 1'b1, 1'b1);
      end else if (pick < 88) begin
        // No first marker: carry on with the current string.
        send_string($urandom_range(12, 1), lo, lo + span, 1'b0, 1'b1);
      end else if (pick < 96) begin
        // No last marker: the next first marker abandons this string.
        send_string($urandom_range(12, 1), lo, lo + span, 1'b1, 1'b0);
      end else if (pick < 97) begin
        send_permutation();
      end else begin
        // Noise: loose characters with random markers.
        repeat ($urandom_range(5, 1)) begin
          send_char(lurt_pkg::CHAR_W'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    char_if.valid      = 1'b0;
    char_if.char_byte  = '0;
    char_if.first_char = 1'b0;
    char_if.last_char  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, no idling. Start with no first marker straight after reset.
    send_word("xyx", 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
    send_word("aaa", 1'b1, 1'b1);
    send_word("abcabcbb", 1'b1, 1'b1);
    // Old sighting of a left of the window must not move the window back.
    send_word("abba", 1'b1, 1'b1);
    // Continue past a last character without a new first marker.
    send_word("cd", 1'b0, 1'b1);
    // Abandon a string midway with a fresh first marker.
    send_word("qr", 1'b1, 1'b0);
    send_char("q", 1'b1, 1'b1);

    send_word("ab", 1'b0, 1'b1);
    send_word("ab", 1'b1, 1'b1);
    send_permutation();

    run_phase(165, 0, 0);
    run_phase(165, 79, 0);
    run_phase(165, 0, 79);
    run_phase(165, 20, 20);

    // Drain: hold valid low and wait for every pending result, then allow for
    // the pipeline latency.
    char_if.valid  = 1'b0;
    recv_stall_pct = 0;
    while (predictor.expected_runs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (predictor.mismatches == 0) begin
      $display("longest_unique_run_tracker verification clean");
    end else begin
      $display("longest_unique_run_tracker verification failed");
    end
    $finish;
  end

endmodule
